>>> rtl/tftci_pkg.sv
// ----------------------------------------------------------------------------
// tftci_pkg
// Shared types, command codes, frame constants and lookup tables for the
// TFT display command interpreter.
// ----------------------------------------------------------------------------
package tftci_pkg;

  // Frame geometry
  localparam int unsigned FRAME_COLS = 240;
  localparam int unsigned FRAME_ROWS = 320;

  // Width that holds any coordinate below the larger frame dimension
  localparam int unsigned FRAME_MAX = (FRAME_COLS > FRAME_ROWS) ? FRAME_COLS : FRAME_ROWS;
  localparam int unsigned MOD_W     = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1;

  // Result field widths
  localparam int unsigned COL_W = 8;
  localparam int unsigned ROW_W = 9;
  localparam int unsigned RGB_W = 24;

  // Command codes
  localparam logic [7:0] CMD_RDID      = 8'h04;
  localparam logic [7:0] CMD_GAMMA     = 8'h26;
  localparam logic [7:0] CMD_DISP_OFF  = 8'h28;
  localparam logic [7:0] CMD_DISP_ON   = 8'h29;
  localparam logic [7:0] CMD_CASET     = 8'h2A;
  localparam logic [7:0] CMD_PASET     = 8'h2B;
  localparam logic [7:0] CMD_RAMWR     = 8'h2C;
  localparam logic [7:0] CMD_MADCTL    = 8'h36;
  localparam logic [7:0] CMD_PIXFMT    = 8'h3A;
  localparam logic [7:0] CMD_FRMCTR1   = 8'hB1;
  localparam logic [7:0] CMD_DFUNCTR   = 8'hB6;
  localparam logic [7:0] CMD_ETMOD     = 8'hB7;
  localparam logic [7:0] CMD_PWCTR1    = 8'hC0;
  localparam logic [7:0] CMD_PWCTR2    = 8'hC1;
  localparam logic [7:0] CMD_VMCTR1    = 8'hC5;
  localparam logic [7:0] CMD_VMCTR2    = 8'hC7;
  localparam logic [7:0] CMD_PWCTRA    = 8'hCB;
  localparam logic [7:0] CMD_PWCTRB    = 8'hCF;
  localparam logic [7:0] CMD_RDID4     = 8'hD3;
  localparam logic [7:0] CMD_PGAMCTRL  = 8'hE0;
  localparam logic [7:0] CMD_NGAMCTRL  = 8'hE1;
  localparam logic [7:0] CMD_DTCA      = 8'hE8;
  localparam logic [7:0] CMD_DTCB      = 8'hEA;
  localparam logic [7:0] CMD_EN3G      = 8'hF2;

  // Identification read-back bytes
  localparam logic [7:0] ID_RDID_1  = 8'h01;
  localparam logic [7:0] ID_RDID_2  = 8'h02;
  localparam logic [7:0] ID_RDID_3  = 8'h03;
  localparam logic [7:0] ID_RDID4_1 = 8'h00;
  localparam logic [7:0] ID_RDID4_2 = 8'h93;
  localparam logic [7:0] ID_RDID4_3 = 8'h41;
  localparam logic [7:0] ID_LAST    = 8'hFF;

  // Reset values
  localparam logic [15:0] COL_END_RST  = 16'd239;
  localparam logic [15:0] PAGE_END_RST = 16'd319;
  localparam logic [7:0]  PIXFMT_RST   = 8'h66;

  typedef struct packed {
    logic [15:0] col_begin;
    logic [15:0] col_end;
    logic [15:0] page_start;
    logic [15:0] page_end;
  } win_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
  } cursor_t;

  typedef struct packed {
    logic [15:0] minor;
    logic [15:0] major;
  } adv_t;

  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [RGB_W-1:0] rgb;
  } pix_res_t;

  typedef logic [MOD_W-1:0] mod_tab_t [256];

  // (i * scale) mod FRAME_COLS for every byte value i
  function automatic mod_tab_t build_col_tab(int unsigned scale);
    mod_tab_t t;
    for (int unsigned i = 0; i < 256; i++) begin
      t[i] = MOD_W'((i * scale) % FRAME_COLS);
    end
    return t;
  endfunction

  function automatic mod_tab_t build_row_tab(int unsigned scale);
    mod_tab_t t;
    for (int unsigned i = 0; i < 256; i++) begin
      t[i] = MOD_W'((i * scale) % FRAME_ROWS);
    end
    return t;
  endfunction

  localparam mod_tab_t COL_HI_TAB = build_col_tab(256);
  localparam mod_tab_t COL_LO_TAB = build_col_tab(1);
  localparam mod_tab_t ROW_HI_TAB = build_row_tab(256);
  localparam mod_tab_t ROW_LO_TAB = build_row_tab(1);

  // Number of argument bytes a command takes (RAMWR handled separately)
  function automatic logic [3:0] arg_count(logic [7:0] c);
    logic [3:0] n;
    case (c)
      CMD_RDID, CMD_CASET, CMD_PASET, CMD_DFUNCTR, CMD_PWCTRA, CMD_RDID4: n = 4'd4;
      CMD_PWCTRB, CMD_DTCA:                                               n = 4'd3;
      CMD_FRMCTR1, CMD_VMCTR1, CMD_DTCB:                                  n = 4'd2;
      CMD_GAMMA, CMD_MADCTL, CMD_PIXFMT, CMD_ETMOD, CMD_PWCTR1, CMD_PWCTR2,
      CMD_VMCTR2, CMD_EN3G:                                               n = 4'd1;
      CMD_PGAMCTRL, CMD_NGAMCTRL:                                         n = 4'd15;
      default:                                                            n = 4'd0;
    endcase
    return n;
  endfunction

  // Step the minor cursor; on window overflow reload it and step the major one
  function automatic adv_t advance(logic [15:0] minor, logic [15:0] mstart,
                                   logic [15:0] mend, logic [15:0] major,
                                   logic [15:0] jstart, logic [15:0] jend);
    adv_t       r;
    logic [15:0] mi;
    logic [15:0] mj;
    mi = minor + 16'd1;
    mj = major;
    if (mi > mend) begin
      mi = mstart;
      mj = major + 16'd1;
      if (mj > jend) begin
        mj = jstart;
      end
    end
    r.minor = mi;
    r.major = mj;
    return r;
  endfunction

endpackage

>>> rtl/tftci_pixel.sv
// ----------------------------------------------------------------------------
// tftci_pixel
// Pixel byte assembly: RGB565 / 18-bit colour packing, frame address
// mapping with swap, mirroring and bounds check, cursor advance.
// ----------------------------------------------------------------------------
module tftci_pixel
  import tftci_pkg::*;
(
  input  logic [7:0]  byte_i,
  input  logic [1:0]  phase_i,
  input  logic [23:0] acc_i,
  input  cursor_t     cur_i,
  input  win_t        win_i,
  input  logic [7:0]  access_i,
  input  logic [7:0]  format_i,
  output logic [1:0]  phase_o,
  output logic [23:0] acc_o,
  output cursor_t     cur_o,
  output pix_res_t    res_o
);

  logic              mode18;
  logic [MOD_W:0]    xsum, ysum;
  logic [MOD_W-1:0]  xmod, ymod;
  logic [23:0]       rgb18, rgb16;
  logic [15:0]       lx, ly, lx_m, ly_m;
  logic              in_frame;
  adv_t              adv_x, adv_y;

  assign mode18 = (format_i[2:1] == 2'b11);

  // Cursor modulo frame size via two byte tables and one correction
  assign xsum = {1'b0, COL_HI_TAB[cur_i.x[15:8]]} + {1'b0, COL_LO_TAB[cur_i.x[7:0]]};
  assign ysum = {1'b0, ROW_HI_TAB[cur_i.y[15:8]]} + {1'b0, ROW_LO_TAB[cur_i.y[7:0]]};
  assign xmod = (xsum >= (MOD_W+1)'(FRAME_COLS)) ?
                MOD_W'(xsum - (MOD_W+1)'(FRAME_COLS)) : xsum[MOD_W-1:0];
  assign ymod = (ysum >= (MOD_W+1)'(FRAME_ROWS)) ?
                MOD_W'(ysum - (MOD_W+1)'(FRAME_ROWS)) : ysum[MOD_W-1:0];

  assign rgb18 = acc_i | {16'd0, byte_i};
  assign rgb16 = acc_i | {11'd0, byte_i[7:5], 2'b00, byte_i[4:0], 3'b000};

  // 16-bit mode address: optional x/y swap, bounds check, mirroring
  assign lx       = access_i[1] ? cur_i.y : cur_i.x;
  assign ly       = access_i[1] ? cur_i.x : cur_i.y;
  assign in_frame = (lx < 16'(FRAME_COLS)) && (ly < 16'(FRAME_ROWS));
  assign ly_m     = access_i[7] ? ly : (16'(FRAME_ROWS - 1) - ly);
  assign lx_m     = access_i[6] ? (16'(FRAME_COLS - 1) - lx) : lx;

  assign adv_x = advance(cur_i.x, win_i.col_begin, win_i.col_end,
                         cur_i.y, win_i.page_start, win_i.page_end);
  assign adv_y = advance(cur_i.y, win_i.col_begin, win_i.col_end,
                         cur_i.x, win_i.page_start, win_i.page_end);

  always_comb begin
    phase_o = phase_i;
    acc_o   = acc_i;
    cur_o   = cur_i;
    res_o   = '0;
    if (mode18) begin
      case (phase_i)
        2'd0: begin
          acc_o   = {byte_i, 16'd0};
          phase_o = 2'd1;
        end
        2'd1: begin
          acc_o   = acc_i | {8'd0, byte_i, 8'd0};
          phase_o = 2'd2;
        end
        default: begin
          res_o.valid = 1'b1;
          res_o.col   = COL_W'(xmod);
          res_o.row   = ROW_W'(ymod);
          res_o.rgb   = rgb18;
          cur_o.x     = adv_x.minor;
          cur_o.y     = adv_x.major;
          phase_o     = 2'd0;
          acc_o       = '0;
        end
      endcase
    end else if (phase_i == 2'd0) begin
      acc_o   = {byte_i[7:3], 3'b000, byte_i[2:0], 13'd0};
      phase_o = 2'd1;
    end else begin
      if (in_frame) begin
        res_o.valid = 1'b1;
        res_o.col   = COL_W'(lx_m);
        res_o.row   = ROW_W'(ly_m);
        res_o.rgb   = rgb16;
      end
      if (access_i[5]) begin
        cur_o.y = adv_y.minor;
        cur_o.x = adv_y.major;
      end else begin
        cur_o.x = adv_x.minor;
        cur_o.y = adv_x.major;
      end
      phase_o = 2'd0;
      acc_o   = '0;
    end
  end

endmodule

>>> rtl/tftci_state.sv
// ----------------------------------------------------------------------------
// tftci_state
// Interpreter state registers and command/argument decode. Produces the
// result of the byte being processed.
// ----------------------------------------------------------------------------
module tftci_state
  import tftci_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  logic     hard_reset_i,
  input  logic     is_data_i,
  input  logic [7:0] byte_i,
  output pix_res_t res_o,
  output logic [7:0] read_data_o,
  output logic     display_on_o
);

  logic [3:0]  args_q, args_d;
  logic [7:0]  pend_q, pend_d;
  win_t        win_q, win_d;
  cursor_t     cur_q, cur_d;
  logic [7:0]  access_q, access_d;
  logic [7:0]  format_q, format_d;
  logic [1:0]  phase_q, phase_d;
  logic [23:0] acc_q, acc_d;
  logic [7:0]  rdbyte_q, rdbyte_d;
  logic        on_q, on_d;

  logic [1:0]  pix_phase;
  logic [23:0] pix_acc;
  cursor_t     pix_cur;
  pix_res_t    pix_res;
  logic        do_pix;
  logic [3:0]  cmd_args;

  tftci_pixel u_pixel (
    .byte_i   (byte_i),
    .phase_i  (phase_q),
    .acc_i    (acc_q),
    .cur_i    (cur_q),
    .win_i    (win_q),
    .access_i (access_q),
    .format_i (format_q),
    .phase_o  (pix_phase),
    .acc_o    (pix_acc),
    .cur_o    (pix_cur),
    .res_o    (pix_res)
  );

  assign cmd_args = arg_count(byte_i);

  always_comb begin
    args_d   = args_q;
    pend_d   = pend_q;
    win_d    = win_q;
    cur_d    = cur_q;
    access_d = access_q;
    format_d = format_q;
    phase_d  = phase_q;
    acc_d    = acc_q;
    rdbyte_d = rdbyte_q;
    on_d     = on_q;
    do_pix   = 1'b0;

    if (hard_reset_i) begin
      args_d   = '0;
      pend_d   = '0;
      win_d    = '{col_begin: '0, col_end: COL_END_RST,
                   page_start: '0, page_end: PAGE_END_RST};
      cur_d    = '0;
      access_d = '0;
      format_d = PIXFMT_RST;
      phase_d  = '0;
      acc_d    = '0;
      rdbyte_d = '0;
      on_d     = 1'b0;
    end else if (args_q != 4'd0) begin
      // Argument byte, regardless of the D/C line
      case (pend_q)
        CMD_RDID: begin
          case (args_q)
            4'd4:    rdbyte_d = ID_RDID_1;
            4'd3:    rdbyte_d = ID_RDID_2;
            4'd2:    rdbyte_d = ID_RDID_3;
            default: rdbyte_d = ID_LAST;
          endcase
        end
        CMD_RDID4: begin
          case (args_q)
            4'd4:    rdbyte_d = ID_RDID4_1;
            4'd3:    rdbyte_d = ID_RDID4_2;
            4'd2:    rdbyte_d = ID_RDID4_3;
            default: rdbyte_d = ID_LAST;
          endcase
        end
        CMD_CASET: begin
          case (args_q)
            4'd4:    win_d.col_begin = {byte_i, 8'd0};
            4'd3:    win_d.col_begin = win_q.col_begin | {8'd0, byte_i};
            4'd2:    win_d.col_end   = {byte_i, 8'd0};
            default: win_d.col_end   = win_q.col_end | {8'd0, byte_i};
          endcase
        end
        CMD_PASET: begin
          case (args_q)
            4'd4:    win_d.page_start = {byte_i, 8'd0};
            4'd3:    win_d.page_start = win_q.page_start | {8'd0, byte_i};
            4'd2:    win_d.page_end   = {byte_i, 8'd0};
            default: win_d.page_end   = win_q.page_end | {8'd0, byte_i};
          endcase
        end
        CMD_RAMWR:  do_pix   = 1'b1;
        CMD_MADCTL: access_d = byte_i;
        CMD_PIXFMT: format_d = byte_i;
        default: ;
      endcase
      args_d = args_q - 4'd1;
    end else if (!is_data_i) begin
      case (byte_i)
        CMD_DISP_OFF: on_d = 1'b0;
        CMD_DISP_ON:  on_d = 1'b1;
        CMD_RAMWR: begin
          pend_d = byte_i;
          args_d = (format_q[2:1] == 2'b11) ? 4'd3 : 4'd2;
          if (access_q[5]) begin
            cur_d.y = win_q.col_begin;
            cur_d.x = win_q.page_start;
          end else begin
            cur_d.x = win_q.col_begin;
            cur_d.y = win_q.page_start;
          end
          phase_d = '0;
          acc_d   = '0;
        end
        default: begin
          if (cmd_args != 4'd0) begin
            pend_d = byte_i;
            args_d = cmd_args;
          end
        end
      endcase
    end else begin
      // Bare data byte outside any argument list
      do_pix = 1'b1;
    end

    if (do_pix) begin
      phase_d = pix_phase;
      acc_d   = pix_acc;
      cur_d   = pix_cur;
    end
  end

  assign res_o        = (do_pix && !hard_reset_i) ? pix_res : '0;
  assign read_data_o  = rdbyte_d;
  assign display_on_o = on_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      args_q   <= '0;
      pend_q   <= '0;
      win_q    <= '{col_begin: '0, col_end: COL_END_RST,
                    page_start: '0, page_end: PAGE_END_RST};
      cur_q    <= '0;
      access_q <= '0;
      format_q <= PIXFMT_RST;
      phase_q  <= '0;
      acc_q    <= '0;
      rdbyte_q <= '0;
      on_q     <= 1'b0;
    end else if (step_i) begin
      args_q   <= args_d;
      pend_q   <= pend_d;
      win_q    <= win_d;
      cur_q    <= cur_d;
      access_q <= access_d;
      format_q <= format_d;
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      rdbyte_q <= rdbyte_d;
      on_q     <= on_d;
    end
  end

endmodule

>>> rtl/tft_display_command_interpreter_core.sv
// ----------------------------------------------------------------------------
// tft_display_command_interpreter_core
// Bus byte interpreter for a TFT controller command interface: window,
// access control, pixel format, identification reads and pixel writes.
// ----------------------------------------------------------------------------
//
//   channel | handshake                 | payload
//   --------+---------------------------+--------------------------------------
//   in      | in_valid_i / in_ready_o   | hard_reset_i, is_data_i, byte_in_i
//   out     | out_valid_o / out_ready_i | pixel_valid_o, pixel_col_o,
//           |                           | pixel_row_o, pixel_rgb_o,
//           |                           | read_data_o, display_on_o
//
// One transaction per cycle sustained while the output is not stalled. A byte
// lands in the input register, then the decode/pixel logic updates the
// interpreter state and loads the result register when it is free or draining.
// Reset (rst_ni low) restores the interpreter state and empties both
// registers. A hard_reset_i transaction does the same to the state in-band.
// A stall on the output holds the result register; the input register still
// takes a transaction while the result register waits, and only then fills.
// ----------------------------------------------------------------------------
module tft_display_command_interpreter_core
  import tftci_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              hard_reset_i,
  input  logic              is_data_i,
  input  logic [7:0]        byte_in_i,

  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              pixel_valid_o,
  output logic [COL_W-1:0]  pixel_col_o,
  output logic [ROW_W-1:0]  pixel_row_o,
  output logic [RGB_W-1:0]  pixel_rgb_o,
  output logic [7:0]        read_data_o,
  output logic              display_on_o
);

  // Input register
  logic       in_vld_q;
  logic       hard_q;
  logic       data_q;
  logic [7:0] byte_q;

  // Result register
  logic       out_vld_q;
  pix_res_t   res_q;
  logic [7:0] rd_q;
  logic       on_q;

  logic       step;
  pix_res_t   res_d;
  logic [7:0] rd_d;
  logic       on_d;

  // The held byte is processed when the result register is free or draining
  assign step       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      hard_q <= hard_reset_i;
      data_q <= is_data_i;
      byte_q <= byte_in_i;
    end
  end

  tftci_state u_state (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .hard_reset_i (hard_q),
    .is_data_i    (data_q),
    .byte_i       (byte_q),
    .res_o        (res_d),
    .read_data_o  (rd_d),
    .display_on_o (on_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
      rd_q  <= rd_d;
      on_q  <= on_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign pixel_valid_o = res_q.valid;
  assign pixel_col_o   = res_q.col;
  assign pixel_row_o   = res_q.row;
  assign pixel_rgb_o   = res_q.rgb;
  assign read_data_o   = rd_q;
  assign display_on_o  = on_q;

endmodule

>>> tb/sv/tft_display_command_interpreter_core_tb.sv
// ----------------------------------------------------------------------------
// tft_display_command_interpreter_core_tb
// Self-checking bench for the TFT command interpreter. A short table of bus
// bytes walks the identification reads, the display flag, both pixel modes,
// mode changes in the middle of a pixel and a column window ending at
// 0xFFFF. Random command sequences follow under four idle/stall mixes. Every
// transaction is modeled and each result is compared field by field in order.
// ----------------------------------------------------------------------------
module tft_display_command_interpreter_core_tb;
  import tftci_pkg::*;

  // Data/command line levels
  localparam logic DC_CMD  = 1'b0;
  localparam logic DC_DATA = 1'b1;

  // MADCTL bits used by the pixel path
  localparam logic [7:0] MAD_ROW_ORDER = 8'h80;  // set: no row mirror
  localparam logic [7:0] MAD_COL_ORDER = 8'h40;  // set: column mirror
  localparam logic [7:0] MAD_EXCHANGE  = 8'h20;  // cursor steps along y
  localparam logic [7:0] MAD_SWAP_XY   = 8'h02;  // x/y swap for 16-bit writes

  // Pixel format bits that select 18-bit mode
  localparam logic [7:0] FMT_18BIT = 8'h06;
  localparam logic [7:0] FMT_16BIT = 8'h55;

  localparam int unsigned PHASE_ITEMS  = 350;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  // One result transaction
  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [RGB_W-1:0] rgb;
    logic [7:0]       rd;
    logic             disp;
  } byte_result_t;

  // Directed table row; lit marks a typed-in expectation
  typedef struct packed {
    logic         hr;
    logic         dc;
    logic [7:0]   b;
    logic         lit;
    byte_result_t res;
  } dir_row_t;

  localparam dir_row_t DIRECTED [25] = '{
    // hard reset, byte ignored
    '{1'b1, DC_CMD,  8'hFF,        1'b1, '{1'b0, 8'd0, 9'd0, 24'd0, 8'h00, 1'b0}},
    '{1'b0, DC_CMD,  CMD_DISP_ON,  1'b1, '{1'b0, 8'd0, 9'd0, 24'd0, 8'h00, 1'b1}},
    // RDID4 read-back; a command-level byte in an argument slot is an argument
    '{1'b0, DC_CMD,  CMD_RDID4,    1'b1, '{1'b0, 8'd0, 9'd0, 24'd0, 8'h00, 1'b1}},
    '{1'b0, DC_CMD,  8'h00,        1'b1, '{1'b0, 8'd0, 9'd0, 24'd0, ID_RDID4_1, 1'b1}},
    '{1'b0, DC_DATA, 8'hA5,        1'b1, '{1'b0, 8'd0, 9'd0, 24'd0, ID_RDID4_2, 1'b1}},
    '{1'b0, DC_DATA, 8'h5A,        1'b1, '{1'b0, 8'd0, 9'd0, 24'd0, ID_RDID4_3, 1'b1}},
    '{1'b0, DC_CMD,  CMD_DISP_OFF, 1'b1, '{1'b0, 8'd0, 9'd0, 24'd0, ID_LAST, 1'b1}},
    // 18-bit write at the window origin, extreme bytes
    '{1'b0, DC_CMD,  CMD_RAMWR,    1'b1, '{1'b0, 8'd0, 9'd0, 24'd0, ID_LAST, 1'b1}},
    '{1'b0, DC_DATA, 8'hFF,        1'b1, '{1'b0, 8'd0, 9'd0, 24'd0, ID_LAST, 1'b1}},
    '{1'b0, DC_DATA, 8'h00,        1'b1, '{1'b0, 8'd0, 9'd0, 24'd0, ID_LAST, 1'b1}},
    '{1'b0, DC_DATA, 8'h80,        1'b1, '{1'b1, 8'd0, 9'd0, 24'hFF0080, ID_LAST, 1'b1}},
    // stray data byte starts a pixel, then the mode flips to 16-bit mid-pixel
    '{1'b0, DC_DATA, 8'h12,        1'b0, '0},
    '{1'b0, DC_CMD,  CMD_PIXFMT,   1'b0, '0},
    '{1'b0, DC_DATA, FMT_16BIT,    1'b0, '0},
    '{1'b0, DC_DATA, 8'hAB,        1'b0, '0},
    // all mirror/exchange/swap bits, then a column window ending at 0xFFFF
    '{1'b0, DC_CMD,  CMD_MADCTL,   1'b0, '0},
    '{1'b0, DC_DATA, 8'hE2,        1'b0, '0},
    '{1'b0, DC_CMD,  CMD_CASET,    1'b0, '0},
    '{1'b0, DC_DATA, 8'h01,        1'b0, '0},
    '{1'b0, DC_DATA, 8'h2C,        1'b0, '0},
    '{1'b0, DC_DATA, 8'hFF,        1'b0, '0},
    '{1'b0, DC_DATA, 8'hFF,        1'b0, '0},
    '{1'b0, DC_CMD,  CMD_DISP_OFF, 1'b1, '{1'b0, 8'd0, 9'd0, 24'd0, ID_LAST, 1'b0}},
    '{1'b0, DC_CMD,  CMD_RAMWR,    1'b0, '0},
    '{1'b0, DC_DATA, 8'hF8,        1'b0, '0}
  };

  // Commands that only consume arguments
  localparam logic [7:0] PLAIN_CMDS [15] = '{
    CMD_GAMMA, CMD_FRMCTR1, CMD_DFUNCTR, CMD_ETMOD, CMD_PWCTR1, CMD_PWCTR2,
    CMD_VMCTR1, CMD_VMCTR2, CMD_PWCTRA, CMD_PWCTRB, CMD_PGAMCTRL, CMD_NGAMCTRL,
    CMD_DTCA, CMD_DTCB, CMD_EN3G
  };

  logic clk;
  logic rst_n = 1'b0;

  logic       in_valid   = 1'b0;
  logic       in_ready;
  logic       hard_reset = 1'b0;
  logic       is_data    = 1'b0;
  logic [7:0] byte_in    = 8'h00;

  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             pix_valid;
  logic [COL_W-1:0] pix_col;
  logic [ROW_W-1:0] pix_row;
  logic [RGB_W-1:0] pix_rgb;
  logic [7:0]       read_data;
  logic             display_on;

  // Idle/stall percentages of the current phase
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned n_sent = 0;
  int unsigned n_fail = 0;
  int unsigned n_cycles = 0;

  // Results still owed by the DUT, oldest first
  byte_result_t byte_results_q [$];

  // --------------------------------------------------------------------------
  // Interpreter model state
  // --------------------------------------------------------------------------
  logic [3:0]  m_args;
  logic [7:0]  m_cmd;
  win_t        win;
  logic [15:0] cur_x, cur_y;
  logic [7:0]  madctl;
  logic [7:0]  pixfmt;
  logic [1:0]  phase;
  logic [23:0] acc;
  logic [7:0]  rd_byte;
  logic        disp_on;

  tft_display_command_interpreter_core DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .hard_reset_i (hard_reset),
    .is_data_i    (is_data),
    .byte_in_i    (byte_in),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .pixel_valid_o(pix_valid),
    .pixel_col_o  (pix_col),
    .pixel_row_o  (pix_row),
    .pixel_rgb_o  (pix_rgb),
    .read_data_o  (read_data),
    .display_on_o (display_on)
  );

  function automatic void clear_state();
    m_args         = '0;
    m_cmd          = '0;
    win.col_begin  = '0;
    win.col_end    = COL_END_RST;
    win.page_start = '0;
    win.page_end   = PAGE_END_RST;
    cur_x          = '0;
    cur_y          = '0;
    madctl         = '0;
    pixfmt         = PIXFMT_RST;
    phase          = '0;
    acc            = '0;
    rd_byte        = '0;
    disp_on        = 1'b0;
  endfunction

  function automatic logic [3:0] args_for(logic [7:0] c);
    case (c)
      CMD_RDID, CMD_CASET, CMD_PASET, CMD_DFUNCTR, CMD_PWCTRA, CMD_RDID4: return 4'd4;
      CMD_PWCTRB, CMD_DTCA: return 4'd3;
      CMD_FRMCTR1, CMD_VMCTR1, CMD_DTCB: return 4'd2;
      CMD_GAMMA, CMD_MADCTL, CMD_PIXFMT, CMD_ETMOD, CMD_PWCTR1, CMD_PWCTR2,
      CMD_VMCTR2, CMD_EN3G: return 4'd1;
      CMD_PGAMCTRL, CMD_NGAMCTRL: return 4'd15;
      default: return 4'd0;
    endcase
  endfunction

  // Cursor step inside the window; both cursors wrap at 16 bits
  function automatic void step_cursor(inout logic [15:0] minor, input logic [15:0] lo,
                                      input logic [15:0] hi, inout logic [15:0] major,
                                      input logic [15:0] jlo, input logic [15:0] jhi);
    minor = minor + 16'd1;
    if (minor > hi) begin
      minor = lo;
      major = major + 16'd1;
      if (major > jhi) begin
        major = jlo;
      end
    end
  endfunction

  // One pixel byte; the phase survives a mode change
  function automatic byte_result_t pixel_step(logic [7:0] d);
    byte_result_t r;
    logic [15:0]  lx, ly;
    r = '0;
    if ((pixfmt & FMT_18BIT) == FMT_18BIT) begin
      if (phase == 2'd0) begin
        acc   = {d, 16'h0000};
        phase = 2'd1;
      end else if (phase == 2'd1) begin
        acc   = acc | {8'h00, d, 8'h00};
        phase = 2'd2;
      end else begin
        acc     = acc | {16'h0000, d};
        r.valid = 1'b1;
        r.col   = COL_W'(cur_x % FRAME_COLS);
        r.row   = ROW_W'(cur_y % FRAME_ROWS);
        r.rgb   = acc;
        step_cursor(cur_x, win.col_begin, win.col_end, cur_y, win.page_start, win.page_end);
        phase = 2'd0;
        acc   = '0;
      end
    end else if (phase == 2'd0) begin
      // RGB565 high byte: red and upper green
      acc   = {d[7:3], 3'b000, d[2:0], 13'd0};
      phase = 2'd1;
    end else begin
      acc = acc | {11'd0, d[7:5], 2'b00, d[4:0], 3'b000};
      if ((madctl & MAD_SWAP_XY) != 0) begin
        lx = cur_y;
        ly = cur_x;
      end else begin
        lx = cur_x;
        ly = cur_y;
      end
      if (lx < FRAME_COLS && ly < FRAME_ROWS) begin
        if ((madctl & MAD_ROW_ORDER) == 0) ly = 16'(FRAME_ROWS - 1) - ly;
        if ((madctl & MAD_COL_ORDER) != 0) lx = 16'(FRAME_COLS - 1) - lx;
        r.valid = 1'b1;
        r.col   = COL_W'(lx);
        r.row   = ROW_W'(ly);
        r.rgb   = acc;
      end
      if ((madctl & MAD_EXCHANGE) != 0) begin
        step_cursor(cur_y, win.col_begin, win.col_end, cur_x, win.page_start, win.page_end);
      end else begin
        step_cursor(cur_x, win.col_begin, win.col_end, cur_y, win.page_start, win.page_end);
      end
      phase = 2'd0;
      acc   = '0;
    end
    return r;
  endfunction

  // Expected result of one accepted bus byte; advances the model state
  function automatic byte_result_t interpret_byte(logic hr, logic dc, logic [7:0] d);
    byte_result_t r;
    logic [3:0]   n;
    r = '0;
    if (hr) begin
      clear_state();
    end else if (m_args != 0) begin
      // Argument slot: the D/C line is ignored
      n = m_args;
      case (m_cmd)
        CMD_RDID:
          rd_byte = (n == 4) ? ID_RDID_1 : (n == 3) ? ID_RDID_2 :
                    (n == 2) ? ID_RDID_3 : ID_LAST;
        CMD_RDID4:
          rd_byte = (n == 4) ? ID_RDID4_1 : (n == 3) ? ID_RDID4_2 :
                    (n == 2) ? ID_RDID4_3 : ID_LAST;
        CMD_CASET:
          case (n)
            4'd4:    win.col_begin = {d, 8'h00};
            4'd3:    win.col_begin = win.col_begin | {8'h00, d};
            4'd2:    win.col_end   = {d, 8'h00};
            default: win.col_end   = win.col_end | {8'h00, d};
          endcase
        CMD_PASET:
          case (n)
            4'd4:    win.page_start = {d, 8'h00};
            4'd3:    win.page_start = win.page_start | {8'h00, d};
            4'd2:    win.page_end   = {d, 8'h00};
            default: win.page_end   = win.page_end | {8'h00, d};
          endcase
        CMD_RAMWR:  r = pixel_step(d);
        CMD_MADCTL: madctl = d;
        CMD_PIXFMT: pixfmt = d;
        default: ;
      endcase
      m_args = n - 4'd1;
    end else if (dc == DC_CMD) begin
      case (d)
        CMD_DISP_OFF: disp_on = 1'b0;
        CMD_DISP_ON:  disp_on = 1'b1;
        CMD_RAMWR: begin
          m_cmd  = d;
          m_args = ((pixfmt & FMT_18BIT) == FMT_18BIT) ? 4'd3 : 4'd2;
          if ((madctl & MAD_EXCHANGE) != 0) begin
            cur_y = win.col_begin;
            cur_x = win.page_start;
          end else begin
            cur_x = win.col_begin;
            cur_y = win.page_start;
          end
          phase = 2'd0;
          acc   = '0;
        end
        default: begin
          if (args_for(d) != 0) begin
            m_cmd  = d;
            m_args = args_for(d);
          end
        end
      endcase
    end else begin
      // Data byte with nothing pending goes straight to the pixel path
      r = pixel_step(d);
    end
    r.rd   = rd_byte;
    r.disp = disp_on;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Clock and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    while (n_cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      n_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offer one byte and hold it until the DUT takes it. Valid stays high into
  // the next transaction unless the idle roll opens a gap.
  task automatic drive_byte(input logic hr, input logic dc, input logic [7:0] b,
                            input logic lit, input byte_result_t lit_res);
    byte_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    hard_reset <= hr;
    is_data    <= dc;
    byte_in    <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // accepted at this edge: the model moves in bus order
    r = interpret_byte(hr, dc, b);
    byte_results_q.push_back(lit ? lit_res : r);
    n_sent++;
  endtask

  task automatic send(input logic hr, input logic dc, input logic [7:0] b);
    drive_byte(hr, dc, b, 1'b0, '0);
  endtask

  // Argument slots mostly carry data; now and then a command-level byte
  function automatic logic arg_dc();
    return ($urandom_range(9) == 0) ? DC_CMD : DC_DATA;
  endfunction

  // Drop valid and let every owed result come back
  task automatic hold_until_empty();
    in_valid <= 1'b0;
    do @(posedge clk); while (byte_results_q.size() != 0);
  endtask

  // One random command sequence. Most are well formed with random content so
  // pixel writes and window wrap are reached; the rest is noise.
  task automatic random_scene();
    int unsigned pick;
    int unsigned k;
    logic [7:0]  c;
    logic [15:0] lo, hi;
    pick = $urandom_range(99);
    if (pick < 20) begin
      // column then page window
      for (int w = 0; w < 2; w++) begin
        k = $urandom_range(6);
        if (k == 0) begin
          lo = 16'($urandom);
          hi = 16'($urandom);
        end else if (k == 1) begin
          // window at the top of the 16-bit range: cursor wraps to zero
          lo = 16'hFFF0 + 16'($urandom_range(15));
          hi = 16'hFFFF;
        end else begin
          lo = 16'($urandom_range((w == 1 && $urandom_range(1) == 0) ? 319 : 239));
          hi = lo + 16'($urandom_range(7));
        end
        send(1'b0, DC_CMD, (w == 0) ? CMD_CASET : CMD_PASET);
        send(1'b0, arg_dc(), lo[15:8]);
        send(1'b0, arg_dc(), lo[7:0]);
        send(1'b0, arg_dc(), hi[15:8]);
        send(1'b0, arg_dc(), hi[7:0]);
      end
    end else if (pick < 30) begin
      send(1'b0, DC_CMD, CMD_MADCTL);
      send(1'b0, arg_dc(), 8'($urandom_range(255)));
    end else if (pick < 37) begin
      k = $urandom_range(2);
      send(1'b0, DC_CMD, CMD_PIXFMT);
      send(1'b0, arg_dc(), (k == 0) ? FMT_16BIT : (k == 1) ? PIXFMT_RST :
                           8'($urandom_range(255)));
    end else if (pick < 67) begin
      // memory write burst, often running past the loaded argument count
      k = ($urandom_range(3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
      send(1'b0, DC_CMD, CMD_RAMWR);
      repeat (k) begin
        send(1'b0, ($urandom_range(19) == 0) ? DC_CMD : DC_DATA, 8'($urandom_range(255)));
      end
    end else if (pick < 73) begin
      send(1'b0, DC_CMD, $urandom_range(1) ? CMD_DISP_ON : CMD_DISP_OFF);
    end else if (pick < 79) begin
      send(1'b0, DC_CMD, $urandom_range(1) ? CMD_RDID : CMD_RDID4);
      repeat (4) send(1'b0, arg_dc(), 8'($urandom_range(255)));
    end else if (pick < 87) begin
      c = PLAIN_CMDS[$urandom_range(14)];
      send(1'b0, DC_CMD, c);
      repeat (args_for(c)) send(1'b0, arg_dc(), 8'($urandom_range(255)));
    end else if (pick < 95) begin
      send(1'b0, 1'($urandom_range(1)), 8'($urandom_range(255)));
    end else if (pick < 97) begin
      send(1'b1, 1'($urandom_range(1)), 8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(1, 6)) send(1'b0, DC_DATA, 8'($urandom_range(255)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side: check each result transaction against the oldest expectation
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_fail++;
    end
  endtask

  initial begin
    byte_result_t e;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (byte_results_q.size() == 0) begin
          $error("result transaction with nothing expected");
          n_fail++;
        end else begin
          e = byte_results_q.pop_front();
          check_field("pixel_valid", 32'(e.valid), 32'(pix_valid));
          check_field("pixel_col", 32'(e.col), 32'(pix_col));
          check_field("pixel_row", 32'(e.row), 32'(pix_row));
          check_field("pixel_rgb", 32'(e.rgb), 32'(pix_rgb));
          check_field("read_data", 32'(e.rd), 32'(read_data));
          check_field("display_on", 32'(e.disp), 32'(display_on));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    clear_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, no idling
    for (int i = 0; i < 25; i++) begin
      drive_byte(DIRECTED[i].hr, DIRECTED[i].dc, DIRECTED[i].b,
                 DIRECTED[i].lit, DIRECTED[i].res);
    end

    // random phases; the sender waits for a clean slate between them
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      while (n_sent < 25 + (p + 1) * PHASE_ITEMS) random_scene();
      hold_until_empty();
    end

    // nothing more may come out
    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0 && byte_results_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
